>>> design/rksce_pkg.sv
// Shared types, codes and constants of the RSA key store command engine.
package rksce_pkg;

    localparam int DATA_W        = 16;
    localparam int KEY_SLOTS_DEF = 8;
    localparam int LIST_MAX      = 8;
    localparam int LIST_W        = 4;
    localparam int KEY_W         = 3 * DATA_W;

    localparam logic [3:0] ACT_ADD    = 4'd0;
    localparam logic [3:0] ACT_DELETE = 4'd1;
    localparam logic [3:0] ACT_LIST   = 4'd2;
    localparam logic [3:0] ACT_ENC    = 4'd3;
    localparam logic [3:0] ACT_DEC    = 4'd4;
    localparam logic [3:0] ACT_SIGN   = 4'd5;
    localparam logic [3:0] ACT_VERIFY = 4'd6;
    localparam logic [3:0] ACT_STATS  = 4'd7;
    localparam logic [3:0] ACT_CLEAR  = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BADPAR  = 3'd2;
    localparam logic [2:0] ST_NOKEY   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    typedef enum logic [1:0] {
        MM_RED,
        MM_ACC,
        MM_SQR
    } mm_op_t;

    typedef enum logic [2:0] {
        RES_PLAIN,
        RES_ADD,
        RES_CALC,
        RES_HEAD,
        RES_ENTRY,
        RES_STATS
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LK_RD,
        S_LK_CMP,
        S_ME_INIT,
        S_ME_RED,
        S_ME_BIT,
        S_ME_MUL,
        S_ME_SQR,
        S_LIST_SCAN,
        S_LIST_RD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      scan_clr;
        logic      scan_inc;
        logic      lk_take;
        logic      me_init;
        logic      mm_start;
        mm_op_t    mm_op;
        logic      emit;
        res_kind_t kind;
        logic [2:0] code;
    } cmd_t;

    typedef struct packed {
        logic [3:0] action;
        logic       free_found;
        logic       slot_bad;
        logic       n_small;
        logic       lk_hit;
        logic       lk_end;
        logic       data_ge_n;
        logic       cur_valid;
        logic       e_bit;
        logic       bits_done;
        logic       mm_done;
        logic       out_last;
    } sts_t;

endpackage

>>> design/rksce_ram.sv
// Generic single-port-write, registered-read RAM.
module rksce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/rksce_mmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle.
module rksce_mmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rksce_pkg::DATA_W-1:0] x,
    input  logic [rksce_pkg::DATA_W-1:0] y,
    input  logic [rksce_pkg::DATA_W-1:0] n,
    output logic                      done,
    output logic [rksce_pkg::DATA_W-1:0] res
);
    import rksce_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [DATA_W-1:0] r_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] n_reg;
    logic [DATA_W+1:0] t;
    logic [DATA_W+1:0] n1;
    logic [DATA_W+1:0] n2;
    logic [DATA_W+1:0] red;
    logic [DATA_W-1:0] r_next;

    always_comb
    begin
        n1 = {2'b00, n_reg};
        n2 = {1'b0, n_reg, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (y_reg[DATA_W-1] ? {2'b00, x_reg} : '0);
        if (t >= n2)
        begin
            red = t - n2;
        end
        else if (t >= n1)
        begin
            red = t - n1;
        end
        else
        begin
            red = t;
        end
        r_next = red[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'hF);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'hF)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            x_reg <= x;
            y_reg <= y;
            n_reg <= n;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[DATA_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = r_reg;
endmodule

>>> design/rksce_dp.sv
// Datapath: command registers, key table, exponentiation registers, counters and result.
module rksce_dp #(
    parameter int KEY_SLOTS = rksce_pkg::KEY_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rksce_pkg::cmd_t   cmd,
    output rksce_pkg::sts_t   sts,
    input  logic [3:0]        action,
    input  logic [15:0]       modulus,
    input  logic [15:0]       public_exp,
    input  logic [15:0]       private_exp,
    input  logic [7:0]        slot_index,
    input  logic [15:0]       data_word,
    input  logic [15:0]       signature,
    output logic [2:0]        status,
    output logic [5:0]        slot_out,
    output logic [15:0]       value,
    output logic              matches_res,
    output logic [6:0]        key_count,
    output logic [15:0]       listed_modulus,
    output logic [15:0]       listed_exp,
    output logic [31:0]       enc_total,
    output logic [31:0]       dec_total,
    output logic [15:0]       sign_total,
    output logic [15:0]       check_total,
    output logic              last
);
    import rksce_pkg::*;

    localparam int AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [3:0]           act_reg;
    logic [DATA_W-1:0]    n_reg;
    logic [DATA_W-1:0]    e_reg;
    logic [DATA_W-1:0]    d_reg;
    logic [7:0]           slot_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [DATA_W-1:0]    sig_reg;
    logic [DATA_W-1:0]    dfound_reg;
    logic [KEY_SLOTS-1:0] valid_reg;
    logic [6:0]           cnt_reg;
    logic [AW-1:0]        scan_reg;
    logic [LIST_W-1:0]    listed_reg;
    logic [DATA_W-1:0]    acc_reg;
    logic [DATA_W-1:0]    b_reg;
    logic [DATA_W-1:0]    ebits_reg;
    logic [4:0]           bitcnt_reg;
    mm_op_t               op_reg;
    logic [31:0]          enc_reg;
    logic [31:0]          dec_reg;
    logic [15:0]          sign_reg;
    logic [15:0]          check_reg;

    logic                 free_found;
    logic [AW-1:0]        free_idx;
    logic [LIST_W-1:0]    lim;
    logic [KEY_W-1:0]     rdata;
    logic                 ram_we;
    logic [DATA_W-1:0]    mm_x;
    logic [DATA_W-1:0]    mm_y;
    logic                 mm_done;
    logic [DATA_W-1:0]    mm_res;
    logic [DATA_W-1:0]    calc;
    logic [AW-1:0]        del_idx;
    logic [DATA_W-1:0]    base_init;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = KEY_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign lim     = (cnt_reg > 7'(LIST_MAX)) ? LIST_W'(LIST_MAX) : cnt_reg[LIST_W-1:0];
    assign calc    = (n_reg < 16'd2) ? '0 : acc_reg;
    assign ram_we  = cmd.emit && (cmd.kind == RES_ADD);
    assign del_idx = slot_reg[AW-1:0];

    always_comb
    begin
        if (act_reg == ACT_ENC)
        begin
            base_init = {8'h00, data_reg[7:0]};
        end
        else if (act_reg == ACT_VERIFY)
        begin
            base_init = sig_reg;
        end
        else
        begin
            base_init = data_reg;
        end
    end

    rksce_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_SLOTS)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({n_reg, e_reg, d_reg}),
        .raddr (scan_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        unique case (cmd.mm_op)
            MM_RED:
            begin
                mm_x = 16'd1;
                mm_y = base_init;
            end
            MM_ACC:
            begin
                mm_x = acc_reg;
                mm_y = b_reg;
            end
            default:
            begin
                mm_x = b_reg;
                mm_y = b_reg;
            end
        endcase
    end

    rksce_mmul u_mmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .n     (n_reg),
        .done  (mm_done),
        .res   (mm_res)
    );

    always_comb
    begin
        sts.action     = act_reg;
        sts.free_found = free_found;
        sts.slot_bad   = (slot_reg >= 8'(KEY_SLOTS));
        sts.n_small    = (n_reg < 16'd2);
        sts.lk_hit     = valid_reg[scan_reg] && (rdata[KEY_W-1 -: DATA_W] == n_reg)
                         && (rdata[2*DATA_W-1 -: DATA_W] == e_reg);
        sts.lk_end     = (scan_reg == AW'(KEY_SLOTS - 1));
        sts.data_ge_n  = (data_reg >= n_reg);
        sts.cur_valid  = valid_reg[scan_reg];
        sts.e_bit      = ebits_reg[0];
        sts.bits_done  = (bitcnt_reg == 5'd16);
        sts.mm_done    = mm_done;
        sts.out_last   = last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            n_reg    <= modulus;
            e_reg    <= public_exp;
            d_reg    <= private_exp;
            slot_reg <= slot_index;
            data_reg <= data_word;
            sig_reg  <= signature;
        end
        if (cmd.lk_take)
        begin
            dfound_reg <= rdata[DATA_W-1:0];
        end
        if (cmd.mm_start)
        begin
            op_reg <= cmd.mm_op;
        end
        if (cmd.me_init)
        begin
            acc_reg    <= 16'd1;
            bitcnt_reg <= '0;
            b_reg      <= base_init;
            if ((act_reg == ACT_DEC) || (act_reg == ACT_SIGN))
            begin
                ebits_reg <= dfound_reg;
            end
            else
            begin
                ebits_reg <= e_reg;
            end
        end
        else if (mm_done)
        begin
            unique case (op_reg)
                MM_ACC:
                begin
                    acc_reg <= mm_res;
                end
                MM_RED:
                begin
                    b_reg <= mm_res;
                end
                default:
                begin
                    b_reg      <= mm_res;
                    ebits_reg  <= {1'b0, ebits_reg[DATA_W-1:1]};
                    bitcnt_reg <= bitcnt_reg + 5'd1;
                end
            endcase
        end
        if (cmd.emit)
        begin
            status         <= cmd.code;
            slot_out       <= '0;
            value          <= '0;
            matches_res    <= 1'b0;
            key_count      <= '0;
            listed_modulus <= '0;
            listed_exp     <= '0;
            enc_total      <= '0;
            dec_total      <= '0;
            sign_total     <= '0;
            check_total    <= '0;
            last           <= 1'b1;
            case (cmd.kind)
                RES_ADD:
                begin
                    slot_out <= 6'(free_idx);
                end
                RES_CALC:
                begin
                    if (act_reg == ACT_VERIFY)
                    begin
                        matches_res <= (calc == data_reg);
                    end
                    else if (act_reg == ACT_DEC)
                    begin
                        value <= {8'h00, calc[7:0]};
                    end
                    else
                    begin
                        value <= calc;
                    end
                end
                RES_HEAD:
                begin
                    key_count <= cnt_reg;
                    last      <= (lim == '0);
                end
                RES_ENTRY:
                begin
                    listed_modulus <= rdata[KEY_W-1 -: DATA_W];
                    listed_exp     <= rdata[2*DATA_W-1 -: DATA_W];
                    last           <= ((listed_reg + LIST_W'(1)) == lim);
                end
                RES_STATS:
                begin
                    enc_total   <= enc_reg;
                    dec_total   <= dec_reg;
                    sign_total  <= sign_reg;
                    check_total <= check_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cnt_reg    <= '0;
            scan_reg   <= '0;
            listed_reg <= '0;
            enc_reg    <= '0;
            dec_reg    <= '0;
            sign_reg   <= '0;
            check_reg  <= '0;
        end
        else
        begin
            if (cmd.scan_clr || (cmd.emit && (cmd.kind == RES_HEAD)))
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc || (cmd.emit && (cmd.kind == RES_ENTRY)))
            begin
                scan_reg <= scan_reg + AW'(1);
            end
            if (cmd.emit && (cmd.kind == RES_HEAD))
            begin
                listed_reg <= '0;
            end
            else if (cmd.emit && (cmd.kind == RES_ENTRY))
            begin
                listed_reg <= listed_reg + LIST_W'(1);
            end
            if (ram_we)
            begin
                valid_reg[free_idx] <= 1'b1;
                cnt_reg             <= cnt_reg + 7'd1;
            end
            if (cmd.emit && (cmd.code == ST_OK))
            begin
                case (act_reg)
                    ACT_DELETE:
                    begin
                        valid_reg[del_idx] <= 1'b0;
                        if (valid_reg[del_idx])
                        begin
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                    ACT_ENC:
                    begin
                        enc_reg <= enc_reg + 32'd1;
                    end
                    ACT_DEC:
                    begin
                        dec_reg <= dec_reg + 32'd1;
                    end
                    ACT_SIGN:
                    begin
                        sign_reg <= sign_reg + 16'd1;
                    end
                    ACT_VERIFY:
                    begin
                        check_reg <= check_reg + 16'd1;
                    end
                    ACT_CLEAR:
                    begin
                        enc_reg   <= '0;
                        dec_reg   <= '0;
                        sign_reg  <= '0;
                        check_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end
endmodule

>>> design/rksce_ctrl.sv
// Controller state machine that sequences each command through the datapath.
module rksce_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rksce_pkg::sts_t sts,
    output rksce_pkg::cmd_t cmd
);
    import rksce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.action) inside
                    ACT_ENC, ACT_VERIFY: state_next = S_ME_INIT;
                    ACT_DEC, ACT_SIGN:   state_next = S_LK_RD;
                    default:             state_next = S_OUT;
                endcase
            end
            S_LK_RD:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (sts.lk_hit)
                begin
                    if ((sts.action == ACT_SIGN) && sts.data_ge_n)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_ME_INIT;
                    end
                end
                else if (sts.lk_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LK_RD;
                end
            end
            S_ME_INIT:
            begin
                state_next = sts.n_small ? S_OUT : S_ME_RED;
            end
            S_ME_RED:
            begin
                if (sts.mm_done)
                begin
                    state_next = S_ME_BIT;
                end
            end
            S_ME_BIT:
            begin
                if (sts.bits_done)
                begin
                    state_next = S_OUT;
                end
                else if (sts.e_bit)
                begin
                    state_next = S_ME_MUL;
                end
                else
                begin
                    state_next = S_ME_SQR;
                end
            end
            S_ME_MUL:
            begin
                if (sts.mm_done)
                begin
                    state_next = S_ME_SQR;
                end
            end
            S_ME_SQR:
            begin
                if (sts.mm_done)
                begin
                    state_next = S_ME_BIT;
                end
            end
            S_LIST_SCAN:
            begin
                if (sts.cur_valid)
                begin
                    state_next = S_LIST_RD;
                end
            end
            S_LIST_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? S_IDLE : S_LIST_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.mm_op = MM_RED;
        cmd.kind  = RES_PLAIN;
        cmd.code  = ST_OK;
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_DISPATCH:
            begin
                unique case (sts.action)
                    ACT_ADD:
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = sts.free_found ? RES_ADD : RES_PLAIN;
                        cmd.code = sts.free_found ? ST_OK : ST_FULL;
                    end
                    ACT_DELETE:
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = sts.slot_bad ? ST_BADPAR : ST_OK;
                    end
                    ACT_LIST:
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = RES_HEAD;
                    end
                    ACT_DEC, ACT_SIGN:
                    begin
                        cmd.scan_clr = 1'b1;
                    end
                    ACT_ENC, ACT_VERIFY:
                    begin
                    end
                    ACT_STATS:
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = RES_STATS;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.emit = 1'b1;
                    end
                    default:
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_INVALID;
                    end
                endcase
            end
            S_LK_CMP:
            begin
                if (sts.lk_hit)
                begin
                    cmd.lk_take = 1'b1;
                    if ((sts.action == ACT_SIGN) && sts.data_ge_n)
                    begin
                        cmd.emit = 1'b1;
                        cmd.code = ST_BADPAR;
                    end
                end
                else if (sts.lk_end)
                begin
                    cmd.emit = 1'b1;
                    cmd.code = ST_NOKEY;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_ME_INIT:
            begin
                if (sts.n_small)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = RES_CALC;
                end
                else
                begin
                    cmd.me_init  = 1'b1;
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_RED;
                end
            end
            S_ME_BIT:
            begin
                if (sts.bits_done)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = RES_CALC;
                end
                else
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = sts.e_bit ? MM_ACC : MM_SQR;
                end
            end
            S_ME_MUL:
            begin
                if (sts.mm_done)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = MM_SQR;
                end
            end
            S_LIST_SCAN:
            begin
                cmd.scan_inc = !sts.cur_valid;
            end
            S_LIST_RD:
            begin
                cmd.emit = 1'b1;
                cmd.kind = RES_ENTRY;
            end
            default:
            begin
            end
        endcase
    end
endmodule

>>> design/rsa_key_store_command_engine.sv
// Top level of the RSA key store command engine.
//
// One command is taken on the input channel (in_valid/in_ready) and its
// results leave on the output channel (out_valid/out_ready), the final one
// marked by last. A list command gives a header and then one result per
// stored key, at most eight; every other command gives exactly one result.
// Commands are handled one at a time: in_ready is high only while the block
// is idle, so the next transfer is taken the cycle after the final result.
// Add, delete, stats, clear and an invalid action are answered from the
// dispatch state; a list walks the key table, passing over free slots.
// Encrypt, verify, decrypt and sign reduce the base modulo the modulus and
// then run square-and-multiply over all 16 exponent bits, lowest first, on a
// bit-serial modular multiplier. Decrypt and sign first search the key
// table slot by slot for the modulus and public exponent.
// A stalled receiver holds the result register and the whole engine.
// Reset empties the key table and clears the four usage counters.
module rsa_key_store_command_engine #(
    parameter int KEY_SLOTS = rksce_pkg::KEY_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  action,
    input  logic [15:0] modulus,
    input  logic [15:0] public_exp,
    input  logic [15:0] private_exp,
    input  logic [7:0]  slot_index,
    input  logic [15:0] data_word,
    input  logic [15:0] signature,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  slot_out,
    output logic [15:0] value,
    output logic        matches_res,
    output logic [6:0]  key_count,
    output logic [15:0] listed_modulus,
    output logic [15:0] listed_exp,
    output logic [31:0] enc_total,
    output logic [31:0] dec_total,
    output logic [15:0] sign_total,
    output logic [15:0] check_total,
    output logic        last
);
    import rksce_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rksce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rksce_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (action),
        .modulus        (modulus),
        .public_exp     (public_exp),
        .private_exp    (private_exp),
        .slot_index     (slot_index),
        .data_word      (data_word),
        .signature      (signature),
        .status         (status),
        .slot_out       (slot_out),
        .value          (value),
        .matches_res    (matches_res),
        .key_count      (key_count),
        .listed_modulus (listed_modulus),
        .listed_exp     (listed_exp),
        .enc_total      (enc_total),
        .dec_total      (dec_total),
        .sign_total     (sign_total),
        .check_total    (check_total),
        .last           (last)
    );
endmodule

>>> design/rksce_checker.sv
// Port-level checker for the RSA key store command engine, with its bind.
module rksce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       last
);
    import rksce_pkg::*;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input and output sides active together.");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("A second transfer was offered while a command was in work.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && !out_valid))
        else $error("Engine did not return to idle after the final result.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_INVALID))
        else $error("Result carries an unknown status code.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(last)))
        else $error("Stalled result changed.");
endmodule

bind rsa_key_store_command_engine rksce_checker u_rksce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .last      (last)
);
